[src/mst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multitouch slot tracker
// Request and response payloads, event modes, contact actions, CSR indices,
// the contact record and the scale constant.
// ----------------------------------------------------------------------------
package mst_pkg;

   localparam int unsigned FULL_SCALE = 10000;

   typedef enum logic [2:0] {
      MODE_SLOT  = 3'd0,
      MODE_TRACK = 3'd1,
      MODE_POS_X = 3'd2,
      MODE_POS_Y = 3'd3,
      MODE_KEY   = 3'd4,
      MODE_SYNC  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ACT_DOWN = 2'd0,
      ACT_MOVE = 2'd1,
      ACT_UP   = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      CSR_X_MIN  = 3'd0,
      CSR_X_MAX  = 3'd1,
      CSR_Y_MIN  = 3'd2,
      CSR_Y_MAX  = 3'd3,
      CSR_MULTI  = 3'd4,
      CSR_SWAP   = 3'd5,
      CSR_INV_X  = 3'd6,
      CSR_INV_Y  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic               link_connected;
   } req_type;

   typedef struct packed {
      logic [13:0] pos_x;
      logic [13:0] pos_y;
      logic [1:0]  action;
      logic [3:0]  pointer_id;
      logic        last;
   } rsp_type;

   // one contact handed from the front part to the back part
   typedef struct packed {
      logic signed [31:0] raw_x;
      logic signed [31:0] raw_y;
      logic [1:0]         action;
      logic [3:0]         pointer_id;
      logic               last;
   } contact_type;

endpackage
`default_nettype wire

[src/mst_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mst_front: event decoder and slot walker
// Applies touch events to slot state; on sync walks the slots one per cycle,
// stalling on a full contact queue when linked; emits raw contacts into it.
// ----------------------------------------------------------------------------
module mst_front #(
   parameter int MAX_TOUCH = 10
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 multi_touch,
   input  wire                 req_push,
   input  mst_pkg::req_type    req_data,
   output logic                req_full,
   output logic                c_push,
   output mst_pkg::contact_type c_data,
   input  wire                 c_full,
   output logic                busy
);

   localparam int SW = 4;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [MAX_TOUCH-1:0] act_ff, act_in, was_ff, was_in;
   logic signed [31:0] sx_ff [MAX_TOUCH];
   logic signed [31:0] sy_ff [MAX_TOUCH];
   logic [SW-1:0] cur_ff, cur_in, idx_ff, idx_in;
   logic cur_ok_ff, cur_ok_in, chg_ff, chg_in, link_ff, link_in;
   logic [MAX_TOUCH-1:0] pend;
   logic take, wr_x, wr_y;
   logic [SW-1:0] wslot;
   logic signed [31:0] wval;
   logic [SW-1:0] nxt;
   logic found, live, step;

   assign req_full = (state_ff != ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign take = req_push && !req_full;

   // pending slots at or after the walk index
   always_comb begin
      pend = '0;
      for (int i = 0; i < MAX_TOUCH; i++) begin
         if ((act_ff[i] || was_ff[i]) && (i >= int'(idx_ff)))
            pend[i] = 1'b1;
      end
      found = 1'b0;
      nxt = '0;
      for (int i = MAX_TOUCH - 1; i >= 0; i--) begin
         if (pend[i]) begin
            found = 1'b1;
            nxt = SW'(i);
         end
      end
   end

   always_comb begin
      live = 1'b0;
      for (int i = 0; i < MAX_TOUCH; i++) begin
         if ((act_ff[i] || was_ff[i]) && (i > int'(nxt)))
            live = 1'b1;
      end
   end

   assign step = (state_ff == ST_WALK) && found && !(link_ff && c_full);

   always_comb begin
      c_push = step && link_ff;
      c_data.raw_x = sx_ff[nxt];
      c_data.raw_y = sy_ff[nxt];
      c_data.action = act_ff[nxt] ? (was_ff[nxt] ? mst_pkg::ACT_MOVE : mst_pkg::ACT_DOWN)
                                  : mst_pkg::ACT_UP;
      c_data.pointer_id = nxt;
      c_data.last = !live;
   end

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      was_in = was_ff;
      cur_in = cur_ff;
      cur_ok_in = cur_ok_ff;
      chg_in = chg_ff;
      idx_in = idx_ff;
      link_in = link_ff;
      wr_x = 1'b0;
      wr_y = 1'b0;
      wslot = '0;
      wval = req_data.value;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_data.mode == mst_pkg::MODE_SYNC) begin
                  if (chg_ff) begin
                     state_in = ST_WALK;
                     idx_in = '0;
                     link_in = req_data.link_connected;
                  end
                  chg_in = 1'b0;
               end else if (multi_touch) begin
                  wslot = cur_ff;
                  case (req_data.mode)
                     mst_pkg::MODE_SLOT: begin
                        if (!req_data.value[31] && req_data.value < MAX_TOUCH) begin
                           cur_in = SW'(req_data.value);
                           cur_ok_in = 1'b1;
                        end else begin
                           cur_ok_in = 1'b0;
                        end
                     end
                     mst_pkg::MODE_TRACK: begin
                        if (cur_ok_ff) begin
                           act_in[cur_ff] = !req_data.value[31];
                           chg_in = 1'b1;
                        end
                     end
                     mst_pkg::MODE_POS_X: begin
                        if (cur_ok_ff) begin
                           wr_x = 1'b1;
                           chg_in = 1'b1;
                        end
                     end
                     mst_pkg::MODE_POS_Y: begin
                        if (cur_ok_ff) begin
                           wr_y = 1'b1;
                           chg_in = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end else begin
                  case (req_data.mode)
                     mst_pkg::MODE_POS_X: begin
                        wr_x = 1'b1;
                        chg_in = 1'b1;
                     end
                     mst_pkg::MODE_POS_Y: begin
                        wr_y = 1'b1;
                        chg_in = 1'b1;
                     end
                     mst_pkg::MODE_KEY: begin
                        act_in[0] = (req_data.value != 0);
                        chg_in = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_WALK: begin
            if (!found) begin
               state_in = ST_IDLE;
            end else if (step) begin
               was_in[nxt] = act_ff[nxt];
               idx_in = nxt + SW'(1);
               if (int'(nxt) == MAX_TOUCH - 1)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         act_ff <= '0;
         was_ff <= '0;
         cur_ff <= '0;
         cur_ok_ff <= 1'b1;
         chg_ff <= 1'b0;
         idx_ff <= '0;
         link_ff <= 1'b0;
         for (int i = 0; i < MAX_TOUCH; i++) begin
            sx_ff[i] <= '0;
            sy_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         act_ff <= act_in;
         was_ff <= was_in;
         cur_ff <= cur_in;
         cur_ok_ff <= cur_ok_in;
         chg_ff <= chg_in;
         idx_ff <= idx_in;
         link_ff <= link_in;
         if (wr_x)
            sx_ff[wslot] <= wval;
         if (wr_y)
            sy_ff[wslot] <= wval;
      end
   end

endmodule
`default_nettype wire

[src/mst_cq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mst_cq: contact queue
// Small queue of raw contacts between the slot walker and the scaler.
// ----------------------------------------------------------------------------
module mst_cq (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  mst_pkg::contact_type push_data,
   output logic                 full,
   input  wire                  pop,
   output mst_pkg::contact_type pop_data,
   output logic                 empty
);

   mst_pkg::contact_type mem_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ (push && !full);
      rp_in = rp_ff ^ (pop && !empty);
      cnt_in = cnt_ff + 2'(push && !full) - 2'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full)
         mem_ff[wp_ff] <= push_data;
   end

endmodule
`default_nettype wire

[src/mst_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mst_back: coordinate scaler
// Normalizes both axes with a shared restoring divider, then swaps, inverts
// and hands the response to a one-entry output register.
// ----------------------------------------------------------------------------
module mst_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire signed [31:0]    x_minimum,
   input  wire signed [31:0]    x_maximum,
   input  wire signed [31:0]    y_minimum,
   input  wire signed [31:0]    y_maximum,
   input  wire                  swap_axes,
   input  wire                  invert_x,
   input  wire                  invert_y,
   input  wire                  c_empty,
   input  mst_pkg::contact_type c_data,
   output logic                 c_pop,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output mst_pkg::rsp_type     rsp_data,
   output logic                 busy
);

   // quotient below 10000 fits 14 bits; numerator d*10000 below 2^47
   localparam int QW = 14;
   localparam int NW = 47;

   localparam logic [1:0] CLIP_NONE = 2'd0;
   localparam logic [1:0] CLIP_LOW  = 2'd1;
   localparam logic [1:0] CLIP_HIGH = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PREP  = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_NEXT  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   mst_pkg::contact_type ct_ff;
   logic axis_ff, axis_in;
   logic [32:0] d_ff, span_ff;
   logic [1:0] clip_ff;
   logic [NW-1:0] rem_ff;
   logic [QW-1:0] q_ff, nx_ff, ny_ff;
   logic [3:0] bit_ff;
   logic out_v_ff;
   mst_pkg::rsp_type out_ff;

   logic signed [32:0] raw, lo, hi, d_s, sp_s, sp_eff;
   logic [1:0] cls;
   logic [NW-1:0] trial;
   logic [QW-1:0] val, fx, fy, ox, oy;

   assign c_pop = (state_ff == ST_IDLE) && !c_empty;
   assign rsp_empty = !out_v_ff;
   assign rsp_data = out_ff;
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      raw = axis_ff ? 33'(ct_ff.raw_y) : 33'(ct_ff.raw_x);
      lo = axis_ff ? 33'(y_minimum) : 33'(x_minimum);
      hi = axis_ff ? 33'(y_maximum) : 33'(x_maximum);
      d_s = raw - lo;
      sp_s = hi - lo;
      sp_eff = (sp_s[32] || sp_s == '0) ? 33'sd1 : sp_s;
      if (d_s[32] || d_s == '0)
         cls = CLIP_LOW;
      else if (d_s >= sp_eff)
         cls = CLIP_HIGH;
      else
         cls = CLIP_NONE;
      trial = NW'(span_ff) << bit_ff;
      val = (clip_ff == CLIP_LOW) ? '0 :
            (clip_ff == CLIP_HIGH) ? QW'(mst_pkg::FULL_SCALE) : q_ff;
      fx = swap_axes ? ny_ff : nx_ff;
      fy = swap_axes ? nx_ff : ny_ff;
      ox = invert_x ? QW'(mst_pkg::FULL_SCALE) - fx : fx;
      oy = invert_y ? QW'(mst_pkg::FULL_SCALE) - fy : fy;
   end

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      unique case (state_ff)
         ST_IDLE:  if (!c_empty) begin
            state_in = ST_PREP;
            axis_in = 1'b0;
         end
         ST_PREP:  state_in = ST_MUL;
         ST_MUL:   state_in = (clip_ff != CLIP_NONE) ? ST_NEXT : ST_DIV;
         ST_DIV:   if (bit_ff == 4'd0) state_in = ST_NEXT;
         ST_NEXT:  begin
            if (!axis_ff) begin
               axis_in = 1'b1;
               state_in = ST_PREP;
            end else if (!out_v_ff || rsp_pop) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
         if (state_ff == ST_OUT)
            out_v_ff <= 1'b1;
         else if (rsp_pop && out_v_ff)
            out_v_ff <= 1'b0;
      end
      if (c_pop)
         ct_ff <= c_data;
      // stage the offset and span of the current axis, and classify the clipped cases
      if (state_ff == ST_PREP) begin
         d_ff <= d_s;
         span_ff <= sp_eff;
         clip_ff <= cls;
         q_ff <= '0;
         bit_ff <= 4'(QW - 1);
      end
      if (state_ff == ST_MUL)
         rem_ff <= NW'(d_ff) * NW'(mst_pkg::FULL_SCALE);
      if (state_ff == ST_DIV) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            q_ff[bit_ff] <= 1'b1;
         end
         bit_ff <= bit_ff - 4'd1;
      end
      if (state_ff == ST_NEXT) begin
         if (!axis_ff)
            nx_ff <= val;
         else
            ny_ff <= val;
      end
      if (state_ff == ST_OUT) begin
         out_ff.pos_x <= ox;
         out_ff.pos_y <= oy;
         out_ff.action <= ct_ff.action;
         out_ff.pointer_id <= ct_ff.pointer_id;
         out_ff.last <= ct_ff.last;
      end
   end

endmodule
`default_nettype wire

[src/multitouch_slot_tracker_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_top: multitouch slot tracker
// Tracks touch slots from a stream of touch events and reports contacts.
// ----------------------------------------------------------------------------
// Non-sync events are applied to the slot state when taken. A sync with pending
// changes walks the slots one per cycle in the front part, stalling on a full
// queue when linked, and blocks requests until the walk is done; each reported
// contact then passes through the shared 14-step restoring divider in the back
// part, run once per axis unless that axis clips, and waits while the output
// register is still occupied. A two-entry queue decouples the walker from the scaler.
module multitouch_slot_tracker_top #(
   parameter int MAX_TOUCH = 10
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_we,
   input  wire [2:0]         csr_index,
   input  wire [31:0]        csr_wdata,
   input  wire               req_push,
   input  mst_pkg::req_type  req_data,
   output logic              full,
   output logic              empty,
   input  wire               pop,
   output mst_pkg::rsp_type  rsp_data
);

   logic signed [31:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic multi_ff, swap_ff, inv_x_ff, inv_y_ff;
   logic c_push, c_full, c_pop, c_empty, f_busy, b_busy;
   mst_pkg::contact_type c_in, c_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= '0;
         x_max_ff <= 32'sd1;
         y_min_ff <= '0;
         y_max_ff <= 32'sd1;
         multi_ff <= 1'b1;
         swap_ff <= 1'b0;
         inv_x_ff <= 1'b0;
         inv_y_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            mst_pkg::CSR_X_MIN: x_min_ff <= csr_wdata;
            mst_pkg::CSR_X_MAX: x_max_ff <= csr_wdata;
            mst_pkg::CSR_Y_MIN: y_min_ff <= csr_wdata;
            mst_pkg::CSR_Y_MAX: y_max_ff <= csr_wdata;
            mst_pkg::CSR_MULTI: multi_ff <= csr_wdata[0];
            mst_pkg::CSR_SWAP:  swap_ff <= csr_wdata[0];
            mst_pkg::CSR_INV_X: inv_x_ff <= csr_wdata[0];
            mst_pkg::CSR_INV_Y: inv_y_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   mst_front #(.MAX_TOUCH(MAX_TOUCH)) u_front (
      .clock(clock), .reset(reset), .multi_touch(multi_ff),
      .req_push(req_push), .req_data(req_data), .req_full(full),
      .c_push(c_push), .c_data(c_in), .c_full(c_full), .busy(f_busy)
   );

   mst_cq u_cq (
      .clock(clock), .reset(reset), .push(c_push), .push_data(c_in), .full(c_full),
      .pop(c_pop), .pop_data(c_out), .empty(c_empty)
   );

   mst_back u_back (
      .clock(clock), .reset(reset),
      .x_minimum(x_min_ff), .x_maximum(x_max_ff),
      .y_minimum(y_min_ff), .y_maximum(y_max_ff),
      .swap_axes(swap_ff), .invert_x(inv_x_ff), .invert_y(inv_y_ff),
      .c_empty(c_empty), .c_data(c_out), .c_pop(c_pop),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data(rsp_data), .busy(b_busy)
   );

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.pos_x <= 14'd10000 && rsp_data.pos_y <= 14'd10000))
      else $error("response coordinate out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_data))
      else $error("response changed while waiting");

   a_cq_push: assert property (@(posedge clock) disable iff (reset)
      c_push |-> f_busy)
      else $error("contact pushed outside a slot walk");

   a_pop_busy: assert property (@(posedge clock) disable iff (reset)
      c_pop |=> b_busy)
      else $error("scaler idle after taking a contact");

endmodule
`default_nettype wire
